FILE: hdl/svfb_pkg.sv
package svfb_pkg;

    // Frame layout
    localparam logic [3:0] POS_VEL0   = 4'd8;
    localparam logic [3:0] POS_VEL1   = 4'd9;
    localparam logic [3:0] POS_VEL2   = 4'd10;
    localparam logic [3:0] POS_VEL3   = 4'd11;
    localparam logic [3:0] POS_CRC_HI = 4'd12;
    localparam logic [3:0] POS_CRC_LO = 4'd13;

    // Gain reset: 43.7 in Q8.16
    localparam logic [23:0] GAIN_RESET = 24'd2863923;

    // CRC-16/XMODEM generator
    localparam logic [15:0] CRC16_GEN = 16'h1021;

    // Rounding offset for the Q8.16 product
    localparam logic [48:0] ROUND_HALF = 49'h8000;

    // Saturation limits on the rounded magnitude
    localparam logic [32:0] MAG_POS_MAX = 33'h0_7FFF_FFFF;
    localparam logic [32:0] MAG_NEG_MAX = 33'h0_8000_0000;

    // Scaled velocity handed from the scaler to the serializer
    typedef struct packed {
        logic        valid;
        logic [31:0] scaled;
        logic        side;
    } svfb_frame_t;

    // Fixed header bytes, left side (0) and right side (1)
    function automatic logic [7:0] header_byte(input logic side, input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            3'd0:    b = 8'hA5;
            3'd1:    b = side ? 8'h3F : 8'h3E;
            3'd2:    b = 8'h02;
            3'd3:    b = 8'h45;
            3'd4:    b = side ? 8'h02 : 8'h00;
            3'd5:    b = 8'h02;
            3'd6:    b = side ? 8'h96 : 8'h5A;
            3'd7:    b = side ? 8'h2B : 8'h18;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Advance the CRC by one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC16_GEN;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/svfb_scale.sv
module svfb_scale (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [24:0]        velocity_command,
    input  logic                      drive_side,
    input  logic [23:0]               gain,
    output svfb_pkg::svfb_frame_t     frame,
    input  logic                      frame_ready
);

    logic        a_valid_reg;
    logic        a_neg_reg;
    logic [24:0] a_mag_reg;
    logic        a_side_reg;
    logic        b_valid_reg;
    logic        b_neg_reg;
    logic [48:0] b_prod_reg;
    logic        b_side_reg;

    logic        a_move;
    logic        a_free;
    logic        b_move;
    logic        b_free;
    logic [24:0] cmd_bits;
    logic [24:0] mag_next;
    logic [48:0] prod_next;
    logic [48:0] rounded;
    logic [32:0] q;
    logic [31:0] scaled;

    // Stage flow control
    assign b_move   = b_valid_reg && frame_ready;
    assign b_free   = !b_valid_reg || b_move;
    assign a_move   = a_valid_reg && b_free;
    assign a_free   = !a_valid_reg || a_move;
    assign in_ready = a_free;

    // Magnitude of the command
    assign cmd_bits = velocity_command;
    assign mag_next = cmd_bits[24] ? (25'd0 - cmd_bits) : cmd_bits;

    // Product of magnitude and gain
    assign prod_next = {24'd0, a_mag_reg} * {25'd0, gain};

    // Round half away from zero, then saturate and reapply the sign
    assign rounded = b_prod_reg + svfb_pkg::ROUND_HALF;
    assign q       = rounded[48:16];

    always_comb
    begin
        if (b_neg_reg)
        begin
            if (q > svfb_pkg::MAG_NEG_MAX)
            begin
                scaled = 32'd0 - svfb_pkg::MAG_NEG_MAX[31:0];
            end
            else
            begin
                scaled = 32'd0 - q[31:0];
            end
        end
        else
        begin
            if (q > svfb_pkg::MAG_POS_MAX)
            begin
                scaled = svfb_pkg::MAG_POS_MAX[31:0];
            end
            else
            begin
                scaled = q[31:0];
            end
        end
    end

    assign frame.valid  = b_valid_reg;
    assign frame.scaled = scaled;
    assign frame.side   = b_side_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload: capture the item, then the product
    always_ff @(posedge clk)
    begin
        if (a_free && in_valid)
        begin
            a_neg_reg  <= cmd_bits[24];
            a_mag_reg  <= mag_next;
            a_side_reg <= drive_side;
        end
        if (a_move)
        begin
            b_neg_reg  <= a_neg_reg;
            b_prod_reg <= prod_next;
            b_side_reg <= a_side_reg;
        end
    end

endmodule

FILE: hdl/svfb_serial.sv
module svfb_serial (
    input  logic                      clk,
    input  logic                      rst_n,
    input  svfb_pkg::svfb_frame_t     frame,
    output logic                      frame_ready,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                frame_byte,
    output logic [3:0]                byte_position,
    output logic                      last_byte
);

    logic        active_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] scaled_reg;
    logic        side_reg;
    logic [15:0] crc_reg;

    logic        take;
    logic        is_last;
    logic [7:0]  cur_byte;
    logic [15:0] crc_next;

    assign is_last     = (cnt_reg == svfb_pkg::POS_CRC_LO);
    assign take        = active_reg && out_ready;
    assign frame_ready = !active_reg || (take && is_last);

    // Select the byte at the current position
    always_comb
    begin
        case (cnt_reg)
            svfb_pkg::POS_VEL0:   cur_byte = scaled_reg[7:0];
            svfb_pkg::POS_VEL1:   cur_byte = scaled_reg[15:8];
            svfb_pkg::POS_VEL2:   cur_byte = scaled_reg[23:16];
            svfb_pkg::POS_VEL3:   cur_byte = scaled_reg[31:24];
            svfb_pkg::POS_CRC_HI: cur_byte = crc_reg[15:8];
            svfb_pkg::POS_CRC_LO: cur_byte = crc_reg[7:0];
            default:              cur_byte = svfb_pkg::header_byte(side_reg, cnt_reg[2:0]);
        endcase
    end

    assign crc_next = svfb_pkg::crc_byte(crc_reg, cur_byte);

    assign out_valid     = active_reg;
    assign frame_byte    = cur_byte;
    assign byte_position = cnt_reg;
    assign last_byte     = is_last;

    // Control: load a frame, advance on each taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 4'd0;
        end
        else if (frame_ready)
        begin
            active_reg <= frame.valid;
            cnt_reg    <= 4'd0;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg + 4'd1;
        end
    end

    // Payload: hold the frame, fold data bytes into the CRC
    always_ff @(posedge clk)
    begin
        if (frame_ready && frame.valid)
        begin
            scaled_reg <= frame.scaled;
            side_reg   <= frame.side;
            crc_reg    <= 16'h0000;
        end
        else if (take && (cnt_reg[3:2] == 2'b10))
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

FILE: hdl/servo_velocity_frame_builder_top.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     velocity_command[24:0] s, drive_side
// out      output     out_valid / out_ready   frame_byte[7:0], byte_position[3:0], last_byte
// cfg      input      cfg_write_en            cfg_write_data[23:0] (velocity gain, Q8.16)
//
// Each item yields 14 output items, one per cycle while out_ready is high; the
// output serializer sets the rate at which items are accepted.
// After acceptance, the first output item passes the product register, then the frame load.
// Two scaler stages buffer the next items while a frame is still going out.
// Reset clears all valid and count state; the gain returns to 43.7.
module servo_velocity_frame_builder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [24:0] velocity_command,
    input  logic               drive_side,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         frame_byte,
    output logic [3:0]         byte_position,
    output logic               last_byte,
    input  logic               cfg_write_en,
    input  logic [23:0]        cfg_write_data
);

    logic [23:0]           gain_reg;
    svfb_pkg::svfb_frame_t frame;
    logic                  frame_ready;

    // Gain register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= svfb_pkg::GAIN_RESET;
        end
        else if (cfg_write_en)
        begin
            gain_reg <= cfg_write_data;
        end
    end

    svfb_scale u_scale (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .velocity_command (velocity_command),
        .drive_side       (drive_side),
        .gain             (gain_reg),
        .frame            (frame),
        .frame_ready      (frame_ready)
    );

    svfb_serial u_serial (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame),
        .frame_ready   (frame_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_byte    (frame_byte),
        .byte_position (byte_position),
        .last_byte     (last_byte)
    );

endmodule
